FILE: sv/bsa_pkg.sv
package bsa_pkg;

  localparam int unsigned MAX_SLOTS = 256;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned MAP_WORDS = MAX_SLOTS / WORD_BITS;
  localparam int unsigned WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int unsigned BIT_IDX_W = $clog2(WORD_BITS);
  localparam int unsigned SLOT_W = 8;
  localparam int unsigned BSIZE_W = 9;
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(256);
  localparam logic [BSIZE_W-1:0] SLOT_CAP = BSIZE_W'(MAX_SLOTS);

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [SLOT_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  granted_slot;
    logic               is_full;
  } rsp_t;

endpackage

FILE: sv/bitmap_slot_allocator_core.sv
// Channel   | Ports                    | Handshake
// ----------+--------------------------+-------------------------------------
// request   | start, busy, req_i       | transfer when start && !busy
// result    | done_o, rsp_o            | one-cycle strobe, no backpressure
// config    | cfg_we_i, cfg_data_i     | slot count written when cfg_we_i
//
// After a request is accepted, busy stays high while the 64-bit map words are
// scanned in turn by one shared priority encoder and mask unit (4 words). The
// result strobe follows the last scan cycle. Reset sets every map bit free and
// the slot count to 256.
// The receiver cannot stall; a new request may be accepted while done_o is high.
module bitmap_slot_allocator_core
  import bsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  req_t               req_i,
  output logic               done_o,
  output rsp_t               rsp_o,
  input  logic               cfg_we_i,
  input  logic [BSIZE_W-1:0] cfg_data_i
);

  state_e state_q, state_d;
  logic [WORD_IDX_W-1:0] cnt_q, cnt_d;
  logic [WORD_BITS-1:0] map_q [MAP_WORDS];
  logic [BSIZE_W-1:0] bsize_q;
  req_t req_q;
  rsp_t rsp_q, rsp_d;
  logic done_q, done_d;
  logic found_q, found_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic rest_q, rest_d;

  logic [BSIZE_W-1:0] lim;
  logic [WORD_BITS-1:0] word, mask, low1h;
  logic [BIT_IDX_W-1:0] enc;
  logic [BSIZE_W-WORD_IDX_W-BIT_IDX_W+WORD_IDX_W-1:0] lim_word;
  logic last;
  logic below_lim;
  logic wr_en, wr_val;
  logic [SLOT_W-1:0] wr_slot;

  assign lim = (bsize_q > SLOT_CAP) ? SLOT_CAP : bsize_q;
  assign lim_word = lim[BSIZE_W-1:BIT_IDX_W];
  assign word = map_q[cnt_q];
  assign low1h = word & (~word + WORD_BITS'(1));
  assign last = (cnt_q == WORD_IDX_W'(MAP_WORDS - 1));

  // priority encoder: lowest set bit of the current word
  always_comb begin
    enc = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (word[b]) begin
        enc = BIT_IDX_W'(b);
      end
    end
  end

  // bits of the current word that lie below the usable limit
  always_comb begin
    if (lim_word > 3'(cnt_q)) begin
      mask = '1;
    end else if (lim_word == 3'(cnt_q)) begin
      mask = (WORD_BITS'(1) << lim[BIT_IDX_W-1:0]) - WORD_BITS'(1);
    end else begin
      mask = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    found_d = found_q;
    idx_d = idx_q;
    rest_d = rest_q;
    rsp_d = rsp_q;
    done_d = 1'b0;
    wr_en = 1'b0;
    wr_val = 1'b0;
    wr_slot = req_q.slot_index;
    below_lim = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
          cnt_d = '0;
          found_d = 1'b0;
          idx_d = '0;
          rest_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (!found_q) begin
          if (word != '0) begin
            found_d = 1'b1;
            idx_d = {cnt_q, enc};
            rest_d = rest_q | (|(word & ~low1h & mask));
          end
        end else begin
          rest_d = rest_q | (|(word & mask));
        end
        cnt_d = cnt_q + WORD_IDX_W'(1);
        if (last) begin
          state_d = ST_IDLE;
          done_d = 1'b1;
          below_lim = found_d && ({1'b0, idx_d} < lim);
          rsp_d.granted_slot = '0;
          if (req_q.op == OP_ALLOC) begin
            if (below_lim) begin
              wr_en = 1'b1;
              wr_val = 1'b0;
              wr_slot = idx_d;
              rsp_d.status = STAT_OK;
              rsp_d.granted_slot = idx_d;
              rsp_d.is_full = !rest_d;
            end else begin
              rsp_d.status = STAT_FULL;
              rsp_d.is_full = 1'b1;
            end
          end else begin
            if ({1'b0, req_q.slot_index} < lim) begin
              wr_en = 1'b1;
              wr_val = 1'b1;
              rsp_d.status = STAT_OK;
              rsp_d.is_full = 1'b0;
            end else begin
              rsp_d.status = STAT_RANGE;
              rsp_d.is_full = !(below_lim || rest_d);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      found_q <= 1'b0;
      rest_q <= 1'b0;
      done_q <= 1'b0;
      bsize_q <= BSIZE_RESET;
      for (int w = 0; w < MAP_WORDS; w++) begin
        map_q[w] <= '1;
      end
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      found_q <= found_d;
      rest_q <= rest_d;
      done_q <= done_d;
      if (cfg_we_i) begin
        bsize_q <= cfg_data_i;
      end
      if (wr_en) begin
        map_q[wr_slot[SLOT_W-1:BIT_IDX_W]][wr_slot[BIT_IDX_W-1:0]] <= wr_val;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rsp_q <= rsp_d;
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  assign busy = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_SCAN && last))
    else $error("result strobe without a finished scan");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_grant_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && req_q.op == OP_ALLOC && rsp_o.status == STAT_OK |->
      ({1'b0, rsp_o.granted_slot} < lim) &&
      !map_q[rsp_o.granted_slot[SLOT_W-1:BIT_IDX_W]][rsp_o.granted_slot[BIT_IDX_W-1:0]])
    else $error("granted slot out of limit or still free");

  a_release_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && req_q.op == OP_RELEASE && rsp_o.status == STAT_OK |->
      !rsp_o.is_full &&
      map_q[req_q.slot_index[SLOT_W-1:BIT_IDX_W]][req_q.slot_index[BIT_IDX_W-1:0]])
    else $error("released slot not marked free");

endmodule
